FILE: hw/rtl/triggered_sine_tone_burst_defines.svh
// Assertion macros shared by the tone burst RTL.
// Files that check their own logic include this header; it depends on nothing.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef TRIGGERED_SINE_TONE_BURST_DEFINES_SVH
`define TRIGGERED_SINE_TONE_BURST_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TSB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TSB_ASSERT_SAME(lbl, ante, cons, msg)
`define TSB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/tsb_pkg.sv
// Package for the triggered sine tone burst: types, codes, reset values and the
// sine table function. Depends on nothing; every RTL module imports it.
`default_nettype none

package tsb_pkg;

  // Default sizes of the phase accumulator and the quarter-wave table.
  localparam int TSB_PHASE_BITS = 24;
  localparam int TSB_SINE_DEPTH = 256;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN     = 2'd3;

  localparam logic [23:0] RST_PHASE_STEP   = 24'd380436;
  localparam logic [15:0] RST_BURST_LENGTH = 16'd1102;
  localparam logic [14:0] RST_AMPLITUDE    = 15'd32000;
  localparam logic [31:0] RST_COOLDOWN     = 32'd0;

  // Item kinds on the input channel.
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_TRIGGER = 1'b1;

  // Full-scale sine value and pi/2 in Q30.
  localparam logic [14:0] SINE_PEAK   = 15'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [23:0] phase_step;
    logic [15:0] burst_length;
    logic [14:0] amplitude;
    logic [31:0] cooldown;
  } tsb_cfg_t;

  // Load enables of the datapath stages after the input register.
  typedef struct packed {
    logic ld_addr;
    logic ld_entry;
    logic ld_prod;
    logic ld_out;
  } tsb_pipe_t;

  // Divides a Taylor term by (2k)(2k+1) for series step k.
  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int k);
    logic [63:0] res;
    case (k)
      1:       res = term / 64'd6;
      2:       res = term / 64'd20;
      3:       res = term / 64'd42;
      4:       res = term / 64'd72;
      5:       res = term / 64'd110;
      6:       res = term / 64'd156;
      7:       res = term / 64'd210;
      8:       res = term / 64'd272;
      9:       res = term / 64'd342;
      10:      res = term / 64'd420;
      11:      res = term / 64'd506;
      12:      res = term / 64'd600;
      default: res = term;
    endcase
    return res;
  endfunction

  // Sine of a Q30 angle scaled to 32767, rounded and capped. Used only to build
  // constant table entries.
  function automatic logic [14:0] sine_from_x(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x2) >> 30;
      term = taylor_div(term, k);
      if ((k % 2) == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
    return (v > 64'(SINE_PEAK)) ? SINE_PEAK : v[14:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tsb_if.sv
// Valid/ready stream interfaces for the tone burst input and result channels.
// Depends on nothing.
`default_nettype none

interface tsb_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] timestamp;

  modport source (output valid, output func, output timestamp, input ready);
  modport sink   (input valid, input func, input timestamp, output ready);
endinterface

interface tsb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/triggered_sine_tone_burst.sv
// Triggered sine tone burst generator, top level.
// Depends on tsb_pkg, tsb_if, tsb_cfg_regs, tsb_tone_ctrl, tsb_sine_lut and tsb_scaler.
`default_nettype none
`include "triggered_sine_tone_burst_defines.svh"

// This block produces short sine beeps. Each input item is either a trigger
// (func = 1) or a request for one audio sample (func = 0). A trigger whose
// timestamp lies at least the cooldown after the last accepted trigger, with
// the difference taken modulo 2^32, arms a pending burst and gives no result.
// Each sample request gives exactly one signed 16-bit sample: during a burst
// it is amplitude * sin(phase) / 32767 truncated toward zero, and the phase
// then advances by phase_step; outside a burst it is zero, and the request
// that finds a trigger pending loads a fresh burst at phase zero. The block
// takes one item every clock cycle while the output is drained. Every stage
// has its own valid bit and moves up into any empty slot, so while a result
// waits downstream the block keeps accepting until the output register, the
// three datapath stages and the input register are all occupied; after that
// in_ch.ready stays low until the result is taken. A sample request passes
// through the input register, table address, table read and multiply
// stages, then the divide-by-32767 correction into the output register. The
// burst state itself is updated as an item leaves the input register, which
// is what lets items follow each other without gaps. The sine table is constant
// logic built at elaboration, so there is no start-up sweep after reset.
// Registers on the configuration port should be written only while no items
// are in flight.
module triggered_sine_tone_burst import tsb_pkg::*; #(
  parameter int PHASE_BITS       = TSB_PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = TSB_SINE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tsb_in_if.sink                 in_ch,
  tsb_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  tsb_cfg_t              cfg;
  tsb_pipe_t             pipe;
  logic                  active;
  logic [PHASE_BITS-1:0] phase;
  logic [14:0]           entry;
  logic                  neg;
  logic signed [15:0]    sample;

  // Input register and valid bits of the datapath stages.
  logic        s0_v_r, s0_v_nxt;
  logic        s0_func_r;
  logic [31:0] s0_ts_r;
  logic        s1_v_r, s1_v_nxt;
  logic        s2_v_r, s2_v_nxt;
  logic        s3_v_r, s3_v_nxt;
  logic        out_v_r, out_v_nxt;

  // A stage may load when it is empty or when its item moves on this cycle.
  logic free0, free1, free2, free3, free4;
  logic step;

  assign free4 = !out_v_r || out_ch.ready;
  assign free3 = !s3_v_r || free4;
  assign free2 = !s2_v_r || free3;
  assign free1 = !s1_v_r || free2;
  assign free0 = !s0_v_r || free1;

  // The item in the input register is processed as it leaves. Triggers end
  // here; sample requests continue into the datapath.
  assign step = s0_v_r && free1;

  assign pipe.ld_addr  = free1;
  assign pipe.ld_entry = free2;
  assign pipe.ld_prod  = free3;
  assign pipe.ld_out   = free4;

  always_comb begin
    s0_v_nxt  = free0 ? in_ch.valid : s0_v_r;
    s1_v_nxt  = free1 ? (s0_v_r && s0_func_r == FUNC_SAMPLE) : s1_v_r;
    s2_v_nxt  = free2 ? s1_v_r : s2_v_r;
    s3_v_nxt  = free3 ? s2_v_r : s3_v_r;
    out_v_nxt = free4 ? s3_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s0_v_r  <= s0_v_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free0 && in_ch.valid) begin
      s0_func_r <= in_ch.func;
      s0_ts_r   <= in_ch.timestamp;
    end
  end

  tsb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsb_tone_ctrl #(
    .PHASE_BITS (PHASE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .func      (s0_func_r),
    .timestamp (s0_ts_r),
    .active    (active),
    .phase     (phase)
  );

  tsb_sine_lut #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lut (
    .clk    (clk),
    .pipe   (pipe),
    .active (active),
    .phase  (phase),
    .entry  (entry),
    .neg    (neg)
  );

  tsb_scaler u_scale (
    .clk       (clk),
    .pipe      (pipe),
    .amplitude (cfg.amplitude),
    .entry     (entry),
    .neg       (neg),
    .sample    (sample)
  );

  assign in_ch.ready   = free0;
  assign out_ch.valid  = out_v_r;
  assign out_ch.sample = sample;

  // A trigger leaving the input register must not occupy a datapath slot.
  `TSB_ASSERT_NEXT(a_trigger_no_result, step && s0_func_r == FUNC_TRIGGER,
    !s1_v_r, "trigger item entered the sample datapath")

  // A new result can only come from the multiply stage.
  `TSB_ASSERT_SAME(a_out_source, $rose(out_v_r), $past(s3_v_r),
    "result appeared without an item in the multiply stage")

  // A delivered sample never exceeds the programmed amplitude.
  `TSB_ASSERT_SAME(a_sample_bound, out_v_r,
    ($signed(sample) <= $signed(17'(cfg.amplitude))) &&
    ($signed(sample) >= -$signed(17'(cfg.amplitude))),
    "sample magnitude exceeds the amplitude")

endmodule

`default_nettype wire

FILE: hw/rtl/tsb_cfg_regs.sv
// Configuration register file of the tone burst block.
// Depends on tsb_pkg.
`default_nettype none

module tsb_cfg_regs import tsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output tsb_cfg_t               cfg
);

  tsb_cfg_t cfg_r;
  tsb_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP:   cfg_nxt.phase_step   = cfg_wdata[23:0];
        REG_BURST_LENGTH: cfg_nxt.burst_length = cfg_wdata[15:0];
        REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_wdata[14:0];
        REG_COOLDOWN:     cfg_nxt.cooldown     = cfg_wdata[31:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step   <= RST_PHASE_STEP;
      cfg_r.burst_length <= RST_BURST_LENGTH;
      cfg_r.amplitude    <= RST_AMPLITUDE;
      cfg_r.cooldown     <= RST_COOLDOWN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tsb_tone_ctrl.sv
// Burst control state: trigger cooldown, pending flag, frame count and phase.
// Depends on tsb_pkg and the assertion macro header.
`default_nettype none
`include "triggered_sine_tone_burst_defines.svh"

module tsb_tone_ctrl import tsb_pkg::*; #(
  parameter int PHASE_BITS = TSB_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tsb_cfg_t              cfg,
  input  logic                  step,
  input  logic                  func,
  input  logic [31:0]           timestamp,
  output logic                  active,
  output logic [PHASE_BITS-1:0] phase
);

  logic                  pending_r, pending_nxt;
  logic [15:0]           frames_r, frames_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [31:0]           last_time_r, last_time_nxt;
  logic [31:0]           diff;
  logic [PHASE_BITS-1:0] step_ext;

  assign diff     = timestamp - last_time_r;
  assign step_ext = PHASE_BITS'(cfg.phase_step);

  always_comb begin
    pending_nxt   = pending_r;
    frames_nxt    = frames_r;
    phase_nxt     = phase_r;
    last_time_nxt = last_time_r;
    if (step) begin
      if (func == FUNC_TRIGGER) begin
        if (diff >= cfg.cooldown) begin
          pending_nxt   = 1'b1;
          last_time_nxt = timestamp;
        end
      end else if (frames_r != 16'd0) begin
        phase_nxt  = phase_r + step_ext;
        frames_nxt = frames_r - 16'd1;
      end else if (pending_r) begin
        frames_nxt  = cfg.burst_length;
        phase_nxt   = '0;
        pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      frames_r    <= 16'd0;
      phase_r     <= '0;
      last_time_r <= 32'd0;
    end else begin
      pending_r   <= pending_nxt;
      frames_r    <= frames_nxt;
      phase_r     <= phase_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  assign active = (frames_r != 16'd0);
  assign phase  = phase_r;

  // A tone sample consumes exactly one frame.
  `TSB_ASSERT_NEXT(a_frame_count, step && func == FUNC_SAMPLE && frames_r != 16'd0,
    frames_r == $past(frames_r) - 16'd1, "tone sample did not consume one frame")

  // A trigger never disturbs the running tone.
  `TSB_ASSERT_NEXT(a_trigger_keeps_tone, step && func == FUNC_TRIGGER,
    $stable(frames_r) && $stable(phase_r), "trigger changed the tone state")

endmodule

`default_nettype wire

FILE: hw/rtl/tsb_sine_lut.sv
// Quarter-wave sine lookup: quadrant fold into a table address, then the read.
// Depends on tsb_pkg; the table is constant logic built from sine_from_x.
`default_nettype none

module tsb_sine_lut import tsb_pkg::*; #(
  parameter int PHASE_BITS       = TSB_PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = TSB_SINE_DEPTH
) (
  input  logic                  clk,
  input  tsb_pipe_t             pipe,
  input  logic                  active,
  input  logic [PHASE_BITS-1:0] phase,
  output logic [14:0]           entry,
  output logic                  neg
);

  localparam int FRAC_W = PHASE_BITS - 2;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = FRAC_W + IDX_W;
  localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(SINE_TABLE_DEPTH);

  logic [14:0]       rom [SINE_TABLE_DEPTH+1];
  logic [1:0]        quad;
  logic [PROD_W-1:0] pos;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic              neg1_r, zero1_r;
  logic [14:0]       entry_r;
  logic              neg2_r;

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] X = (HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
    assign rom[g] = sine_from_x(X);
  end

  // Position within the quadrant, scaled to the table depth.
  assign quad     = phase[PHASE_BITS-1 -: 2];
  assign pos      = PROD_W'(phase[FRAC_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = pos[PROD_W-1 -: IDX_W];
  assign addr_nxt = quad[0] ? (DEPTH_C - idx) : idx;

  always_ff @(posedge clk) begin
    if (pipe.ld_addr) begin
      addr_r  <= addr_nxt;
      neg1_r  <= quad[1];
      zero1_r <= !active;
    end
    if (pipe.ld_entry) begin
      entry_r <= zero1_r ? 15'd0 : rom[addr_r];
      neg2_r  <= neg1_r && !zero1_r;
    end
  end

  assign entry = entry_r;
  assign neg   = neg2_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tsb_scaler.sv
// Amplitude scaling: multiply by the amplitude, divide by 32767, apply sign.
// Depends on tsb_pkg.
`default_nettype none

module tsb_scaler import tsb_pkg::*; (
  input  logic               clk,
  input  tsb_pipe_t          pipe,
  input  logic [14:0]        amplitude,
  input  logic [14:0]        entry,
  input  logic               neg,
  output logic signed [15:0] sample
);

  logic [29:0]        prod_r;
  logic               neg_r;
  logic [14:0]        q0;
  logic [15:0]        rem;
  logic               corr;
  logic [15:0]        mag;
  logic signed [15:0] sample_r, sample_nxt;

  // p / 32767 = q0 + carry, where q0 = p >> 15 and the remainder estimate
  // (p mod 2^15) + q0 stays below twice the divisor for any 15 x 15 product.
  assign q0   = prod_r[29:15];
  assign rem  = {1'b0, prod_r[14:0]} + {1'b0, q0};
  assign corr = (rem >= {1'b0, SINE_PEAK});
  assign mag  = {1'b0, q0} + 16'(corr);
  assign sample_nxt = neg_r ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (pipe.ld_prod) begin
      prod_r <= 30'(entry) * 30'(amplitude);
      neg_r  <= neg;
    end
    if (pipe.ld_out) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

`default_nettype wire
